/* rtl/olv_pkg.sv */
// olv_pkg: payload types, operation and status codes, and the control/status
// structs shared by the ordered value list controller, datapath and top level.
// No dependencies.
package olv_pkg;

    localparam int VALUE_W = 31;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_DUMP   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [1:0]         operation;
        logic [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] item_value;
        logic [1:0]         status;
        logic               last;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic       load;      // capture the incoming value
        logic       idx_clr;
        logic       idx_inc;
        logic       rd_en;
        logic       rd_next;   // read at idx+1 rather than idx
        logic       wr_en;
        logic       wr_shift;  // write read data at idx, else value at tail
        logic       cnt_inc;
        logic       cnt_dec;
        logic       res_valid;
        logic [1:0] res_status;
        logic       res_last;
        logic       res_data;  // put read data on item_value
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_full;
        logic is_empty;
        logic match;       // read data equals captured value
        logic idx_last;    // idx + 1 == entry count
    } t_dp_stat;

endpackage

/* rtl/olv_ram.sv */
// olv_ram: generic simple dual-port RAM, one write and one registered read
// port. Depends on nothing.
module olv_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/olv_ctrl.sv */
// olv_ctrl: sequencer for append, remove (scan then shift down) and dump.
// Depends on olv_pkg.
module olv_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [1:0]       i_operation,
    input  olv_pkg::t_dp_stat i_stat,
    output olv_pkg::t_ctl_cmd o_cmd,
    output logic             o_busy
);
    import olv_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SC_RD  = 3'd1;
    localparam logic [2:0] S_SC_CMP = 3'd2;
    localparam logic [2:0] S_SH_RD  = 3'd3;
    localparam logic [2:0] S_SH_WR  = 3'd4;
    localparam logic [2:0] S_DM_RD  = 3'd5;
    localparam logic [2:0] S_DM_OUT = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_ctl_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    case (i_operation)
                        OP_APPEND: begin
                            cmd.res_valid = 1'b1;
                            cmd.res_last  = 1'b1;
                            if (i_stat.is_full) begin
                                cmd.res_status = ST_FULL;
                            end else begin
                                cmd.res_status = ST_OK;
                                cmd.wr_en      = 1'b1;
                                cmd.cnt_inc    = 1'b1;
                            end
                        end
                        OP_REMOVE: begin
                            if (i_stat.is_empty) begin
                                cmd.res_valid  = 1'b1;
                                cmd.res_last   = 1'b1;
                                cmd.res_status = ST_NOT_FOUND;
                            end else begin
                                cmd.idx_clr = 1'b1;
                                n_state     = S_SC_RD;
                            end
                        end
                        OP_DUMP: begin
                            if (i_stat.is_empty) begin
                                cmd.res_valid  = 1'b1;
                                cmd.res_last   = 1'b1;
                                cmd.res_status = ST_EMPTY;
                            end else begin
                                cmd.idx_clr = 1'b1;
                                n_state     = S_DM_RD;
                            end
                        end
                        default: ;  // unused code: no result
                    endcase
                end
            end
            S_SC_RD: begin
                cmd.rd_en = 1'b1;
                n_state   = S_SC_CMP;
            end
            S_SC_CMP: begin
                if (i_stat.match) begin
                    n_state = S_SH_RD;
                end else if (i_stat.idx_last) begin
                    cmd.res_valid  = 1'b1;
                    cmd.res_last   = 1'b1;
                    cmd.res_status = ST_NOT_FOUND;
                    n_state        = S_IDLE;
                end else begin
                    cmd.idx_inc = 1'b1;
                    n_state     = S_SC_RD;
                end
            end
            S_SH_RD: begin
                if (i_stat.idx_last) begin
                    cmd.cnt_dec    = 1'b1;
                    cmd.res_valid  = 1'b1;
                    cmd.res_last   = 1'b1;
                    cmd.res_status = ST_OK;
                    n_state        = S_IDLE;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_next = 1'b1;
                    n_state     = S_SH_WR;
                end
            end
            S_SH_WR: begin
                cmd.wr_en    = 1'b1;
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
                n_state      = S_SH_RD;
            end
            S_DM_RD: begin
                cmd.rd_en = 1'b1;
                n_state   = S_DM_OUT;
            end
            S_DM_OUT: begin
                cmd.res_valid  = 1'b1;
                cmd.res_status = ST_OK;
                cmd.res_data   = 1'b1;
                cmd.res_last   = i_stat.idx_last;
                if (i_stat.idx_last) begin
                    n_state = S_IDLE;
                end else begin
                    cmd.idx_inc = 1'b1;
                    n_state     = S_DM_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);
endmodule

/* rtl/olv_datapath.sv */
// olv_datapath: entry store, entry count, walk index, value compare and the
// result register. Depends on olv_pkg and olv_ram.
module olv_datapath #(
    parameter int LIST_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  olv_pkg::t_in_item  i_in,
    input  olv_pkg::t_ctl_cmd  i_cmd,
    output olv_pkg::t_dp_stat  o_stat,
    output logic              o_strobe,
    output olv_pkg::t_out_item o_result
);
    import olv_pkg::*;

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [AW-1:0]      r_idx;
    logic [AW-1:0]      n_idx;
    logic [VALUE_W-1:0] r_value;
    logic               r_res_valid;
    t_out_item          r_res;

    logic [CW-1:0]      idx_plus1;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic [VALUE_W-1:0] rd_data;

    assign idx_plus1 = CW'(r_idx) + CW'(1);
    assign rd_addr   = i_cmd.rd_next ? idx_plus1[AW-1:0] : r_idx;
    assign wr_addr   = i_cmd.wr_shift ? r_idx : r_count[AW-1:0];
    assign wr_data   = i_cmd.wr_shift ? rd_data : i_in.value;

    olv_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (LIST_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (i_cmd.rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - CW'(1);
        end
        n_idx = r_idx;
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = idx_plus1[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_res_valid <= i_cmd.res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_in.value;
        end
        if (i_cmd.res_valid) begin
            r_res.item_value <= i_cmd.res_data ? rd_data : '0;
            r_res.status     <= i_cmd.res_status;
            r_res.last       <= i_cmd.res_last;
        end
    end

    assign o_stat.is_full  = (r_count == CW'(LIST_DEPTH));
    assign o_stat.is_empty = (r_count == '0);
    assign o_stat.match    = (rd_data == r_value);
    assign o_stat.idx_last = (idx_plus1 == r_count);

    assign o_strobe = r_res_valid;
    assign o_result = r_res;
endmodule

/* rtl/ordered_value_list_unit.sv */
// ordered_value_list_unit: top level of the ordered value list.
// Depends on olv_pkg, olv_ctrl, olv_datapath (and through it olv_ram).
//
//  channel   ports                     transaction when
//  --------  ------------------------  ---------------------------------
//  command   start, busy, i_in         start high and busy low at a clock edge
//  result    o_strobe, o_result        o_strobe high for one cycle
//
// Sequencing: append is done in the idle state; its result follows on the next
//   cycle and the unit takes a new command at once. Remove scans the RAM with a
//   read and a compare state per entry up to the match, then moves each later
//   entry down one place with a read and a write state per entry (the single
//   read port sets this). Dump reads then outputs each entry, head to tail.
// Reset: i_rst_n synchronous, active low; clears the count, so the list is
//   empty at once. The RAM keeps old contents and needs no clearing pass.
// Stalls: none on the result side; busy holds commands off while a remove or
//   dump is walking the list.
module ordered_value_list_unit #(
    parameter int LIST_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  olv_pkg::t_in_item  i_in,
    output logic               busy,
    output logic               o_strobe,
    output olv_pkg::t_out_item o_result
);
    import olv_pkg::*;

    t_ctl_cmd w_cmd;
    t_dp_stat w_stat;

    // sequencer: decides each step from the datapath flags
    olv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_in.operation),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_busy      (busy)
    );

    // store, count, index and result register
    olv_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // never grow past the depth
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_stat.is_full && w_cmd.cnt_inc))
        else $error("append written into a full list");

    // never shrink an empty list
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_stat.is_empty && w_cmd.cnt_dec))
        else $error("remove from an empty list");

    // a full report only ever follows a full list
    a_full_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == ST_FULL) |-> $past(w_stat.is_full))
        else $error("full reported while list had room");

    // a dump entry that is not the tail is followed by a read gap, still busy
    a_dump_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |=> (busy && !o_strobe))
        else $error("dump sequence broken after non-final entry");

endmodule
